>>> rtl/sawarq_pkg.sv
// Shared types, constants and helpers for the stop-and-wait command ARQ block.
package sawarq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(MAX_RESULTS);

	localparam logic [15:0] MAX_CMD_LEN = 16'd1400;
	localparam logic [31:0] MASK_RESET  = 32'd1;

	// request kinds
	localparam logic [2:0] KIND_QUEUE = 3'd0;
	localparam logic [2:0] KIND_TICK  = 3'd1;
	localparam logic [2:0] KIND_RESP  = 3'd2;
	localparam logic [2:0] KIND_CMD   = 3'd3;
	localparam logic [2:0] KIND_CONN  = 3'd4;
	localparam logic [2:0] KIND_DISC  = 3'd5;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		ACT_ACCEPTED = 3'd0,
		ACT_REJECTED = 3'd1,
		ACT_SEND_CMD = 3'd2,
		ACT_SEND_RSP = 3'd3,
		ACT_DELIVER  = 3'd4,
		ACT_FAILED   = 3'd5,
		ACT_DISCONN  = 3'd6,
		ACT_CONNECT  = 3'd7
	} action_t;

	// which result the datapath builds in its output register
	typedef enum logic [3:0] {
		OP_REJECT,
		OP_ACCEPT,
		OP_SEND_CAP,
		OP_SEND_HEAD,
		OP_RESP,
		OP_DELIVER,
		OP_FAIL,
		OP_DISC,
		OP_CONN
	} out_op_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] handle;
		logic [31:0] cb_type;
		logic [31:0] cb_data;
	} q_entry_t;

	typedef struct packed {
		logic    capture;
		logic    push;
		logic    pop;
		logic    set_sent;
		logic    clr_sent;
		logic    exp_upd;
		logic    link_set;
		logic    link_clr;
		logic    walk_start;
		logic    walk_adv;
		logic    rd_walk;
		logic    load_out;
		out_op_t out_op;
		logic    out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       link_up;
		logic       empty;
		logic       full;
		logic       len_ok;
		logic       sent_recently;
		logic       head_match;
		logic       seq_ge_exp;
		logic       reason_zero;
		logic       pop_empties;
		logic       walk_end;
		logic       flagged;
		logic       out_free;
	} dp_stat_t;

	function automatic ptr_t ring_next(input ptr_t p);
		ring_next = (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

endpackage

>>> rtl/sawarq_dp.sv
// Datapath: command ring memory, pointers, sequence counters, request capture and output register.
module sawarq_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [2:0]                kind,
	input  logic [31:0]               seq,
	input  logic [15:0]               cmd_handle,
	input  logic [15:0]               cmd_length,
	input  logic [31:0]               callback_type,
	input  logic [31:0]               callback_data,
	input  logic [7:0]                reason,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [31:0]               cfg_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                action,
	output logic [31:0]               out_seq,
	output logic [15:0]               out_handle,
	output logic [31:0]               out_callback_type,
	output logic [31:0]               out_callback_data,
	output logic [7:0]                out_reason,
	output logic                      last,
	input  sawarq_pkg::dp_cmd_t       cmd,
	output sawarq_pkg::dp_stat_t      stat
);

	sawarq_pkg::q_entry_t mem_q [sawarq_pkg::QUEUE_DEPTH];
	sawarq_pkg::q_entry_t rd_q;
	sawarq_pkg::ptr_t     rd_addr;

	sawarq_pkg::ptr_t put_q, send_q, wp_q;
	sawarq_pkg::cnt_t cnt_q;
	logic [31:0]      nps_q, exp_q, mask_q;
	logic             link_q, sent_q, out_valid_q;

	logic [2:0]  cap_kind_q;
	logic [31:0] cap_seq_q, cap_cbt_q, cap_cbd_q;
	logic [15:0] cap_handle_q, cap_len_q;
	logic [7:0]  cap_reason_q;

	sawarq_pkg::action_t out_action_q, nxt_action;
	logic [31:0] out_seq_q, out_cbt_q, out_cbd_q, nxt_seq, nxt_cbt, nxt_cbd;
	logic [15:0] out_handle_q, nxt_handle;
	logic [7:0]  out_reason_q, nxt_reason;
	logic        out_last_q;

	assign cfg_ready = 1'b1;
	assign rd_addr   = cmd.rd_walk ? wp_q : send_q;

	// ring storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[put_q] <= '{seq: nps_q, handle: cap_handle_q,
				cb_type: cap_cbt_q, cb_data: cap_cbd_q};
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cap_kind_q   <= kind;
			cap_seq_q    <= seq;
			cap_handle_q <= cmd_handle;
			cap_len_q    <= cmd_length;
			cap_cbt_q    <= callback_type;
			cap_cbd_q    <= callback_data;
			cap_reason_q <= reason;
		end else if (cmd.push) begin
			// keep the assigned number for the accepted report
			cap_seq_q <= nps_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			put_q  <= '0;
			send_q <= '0;
			wp_q   <= '0;
			cnt_q  <= '0;
			nps_q  <= '0;
			exp_q  <= '0;
			mask_q <= sawarq_pkg::MASK_RESET;
			link_q <= 1'b0;
			sent_q <= 1'b0;
		end else begin
			if (cfg_valid) mask_q <= cfg_data;
			if (cmd.push) begin
				put_q <= sawarq_pkg::ring_next(put_q);
				nps_q <= nps_q + 32'd1;
			end
			if (cmd.pop) send_q <= sawarq_pkg::ring_next(send_q);
			if (cmd.set_sent) sent_q <= 1'b1;
			else if (cmd.clr_sent) sent_q <= 1'b0;
			if (cmd.exp_upd && stat.seq_ge_exp) exp_q <= cap_seq_q + 32'd1;
			if (cmd.link_set) link_q <= 1'b1;
			else if (cmd.link_clr) link_q <= 1'b0;
			if (cmd.walk_start) begin
				wp_q  <= send_q;
				cnt_q <= '0;
			end else if (cmd.walk_adv) begin
				wp_q <= sawarq_pkg::ring_next(wp_q);
				if (cmd.load_out) cnt_q <= cnt_q + sawarq_pkg::cnt_t'(1);
			end
		end
	end

	always_comb begin
		nxt_action = sawarq_pkg::ACT_REJECTED;
		nxt_seq    = '0;
		nxt_handle = '0;
		nxt_cbt    = '0;
		nxt_cbd    = '0;
		nxt_reason = '0;
		case (cmd.out_op)
			sawarq_pkg::OP_ACCEPT: begin
				nxt_action = sawarq_pkg::ACT_ACCEPTED;
				nxt_seq    = cap_seq_q;
				nxt_handle = cap_handle_q;
			end
			sawarq_pkg::OP_SEND_CAP: begin
				nxt_action = sawarq_pkg::ACT_SEND_CMD;
				nxt_seq    = cap_seq_q;
				nxt_handle = cap_handle_q;
			end
			sawarq_pkg::OP_SEND_HEAD: begin
				nxt_action = sawarq_pkg::ACT_SEND_CMD;
				nxt_seq    = rd_q.seq;
				nxt_handle = rd_q.handle;
			end
			sawarq_pkg::OP_RESP: begin
				nxt_action = sawarq_pkg::ACT_SEND_RSP;
				nxt_seq    = cap_seq_q;
			end
			sawarq_pkg::OP_DELIVER: begin
				nxt_action = sawarq_pkg::ACT_DELIVER;
				nxt_seq    = cap_seq_q;
				nxt_handle = cap_handle_q;
			end
			sawarq_pkg::OP_FAIL: begin
				nxt_action = sawarq_pkg::ACT_FAILED;
				nxt_seq    = rd_q.seq;
				nxt_handle = rd_q.handle;
				nxt_cbt    = rd_q.cb_type;
				nxt_cbd    = rd_q.cb_data;
			end
			sawarq_pkg::OP_DISC: begin
				nxt_action = sawarq_pkg::ACT_DISCONN;
				nxt_reason = cap_reason_q;
			end
			sawarq_pkg::OP_CONN: begin
				nxt_action = sawarq_pkg::ACT_CONNECT;
				nxt_reason = cap_reason_q;
			end
			default: nxt_action = sawarq_pkg::ACT_REJECTED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_action_q <= nxt_action;
			out_seq_q    <= nxt_seq;
			out_handle_q <= nxt_handle;
			out_cbt_q    <= nxt_cbt;
			out_cbd_q    <= nxt_cbd;
			out_reason_q <= nxt_reason;
			out_last_q   <= cmd.out_last;
		end
	end

	assign out_valid         = out_valid_q;
	assign action            = out_action_q;
	assign out_seq           = out_seq_q;
	assign out_handle        = out_handle_q;
	assign out_callback_type = out_cbt_q;
	assign out_callback_data = out_cbd_q;
	assign out_reason        = out_reason_q;
	assign last              = out_last_q;

	always_comb begin
		stat.kind          = cap_kind_q;
		stat.link_up       = link_q;
		stat.empty         = (put_q == send_q);
		stat.full          = (sawarq_pkg::ring_next(put_q) == send_q);
		stat.len_ok        = (cap_len_q <= sawarq_pkg::MAX_CMD_LEN);
		stat.sent_recently = sent_q;
		stat.head_match    = (rd_q.seq == cap_seq_q);
		stat.seq_ge_exp    = (cap_seq_q >= exp_q);
		stat.reason_zero   = (cap_reason_q == 8'd0);
		stat.pop_empties   = (sawarq_pkg::ring_next(send_q) == put_q);
		stat.walk_end      = (wp_q == put_q) ||
			(cnt_q == sawarq_pkg::cnt_t'(sawarq_pkg::MAX_RESULTS - 1));
		stat.flagged       = ((rd_q.cb_type & mask_q) != 32'd0);
		stat.out_free      = !out_valid_q || !out_stall;
	end

endmodule

>>> rtl/sawarq_ctrl.sv
// Controller: sequences each request through decision and, where needed, memory fetch, ring walk and result emission.
module sawarq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  sawarq_pkg::dp_stat_t  stat,
	output sawarq_pkg::dp_cmd_t   cmd
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DECIDE   = 6'b000010,
		S_FETCH    = 6'b000100,
		S_EMIT     = 6'b001000,
		S_WALK_RD  = 6'b010000,
		S_WALK_CHK = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	sawarq_pkg::out_op_t op1_q, op1_d, op2_q, op2_d;
	logic                has2_q, has2_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		op1_d   = op1_q;
		op2_d   = op2_q;
		has2_d  = has2_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				has2_d = 1'b0;
				unique case (stat.kind)
					sawarq_pkg::KIND_QUEUE: begin
						state_d = S_EMIT;
						if (!stat.link_up || !stat.len_ok || stat.full) begin
							op1_d = sawarq_pkg::OP_REJECT;
						end else begin
							cmd.push = 1'b1;
							if (stat.empty) begin
								cmd.set_sent = 1'b1;
								op1_d        = sawarq_pkg::OP_SEND_CAP;
								op2_d        = sawarq_pkg::OP_ACCEPT;
								has2_d       = 1'b1;
							end else begin
								op1_d = sawarq_pkg::OP_ACCEPT;
							end
						end
					end
					sawarq_pkg::KIND_TICK: begin
						if (!stat.link_up || stat.empty) begin
							state_d = S_IDLE;
						end else if (stat.sent_recently) begin
							cmd.clr_sent = 1'b1;
							state_d      = S_IDLE;
						end else begin
							op1_d   = sawarq_pkg::OP_SEND_HEAD;
							state_d = S_EMIT;
						end
					end
					sawarq_pkg::KIND_RESP: begin
						if (stat.empty || !stat.head_match) begin
							state_d = S_IDLE;
						end else begin
							cmd.pop = 1'b1;
							if (stat.pop_empties) begin
								state_d = S_IDLE;
							end else begin
								// new head needs a read before it goes out
								cmd.set_sent = 1'b1;
								op1_d        = sawarq_pkg::OP_SEND_HEAD;
								state_d      = S_FETCH;
							end
						end
					end
					sawarq_pkg::KIND_CMD: begin
						cmd.exp_upd = 1'b1;
						op1_d       = sawarq_pkg::OP_RESP;
						op2_d       = sawarq_pkg::OP_DELIVER;
						has2_d      = stat.seq_ge_exp;
						state_d     = S_EMIT;
					end
					sawarq_pkg::KIND_CONN: begin
						cmd.link_set = stat.reason_zero;
						op1_d        = sawarq_pkg::OP_CONN;
						state_d      = S_EMIT;
					end
					sawarq_pkg::KIND_DISC: begin
						cmd.link_clr   = 1'b1;
						cmd.walk_start = 1'b1;
						state_d        = S_WALK_RD;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_FETCH: state_d = S_EMIT;
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_op   = op1_q;
					cmd.out_last = !has2_q;
					if (has2_q) begin
						op1_d  = op2_q;
						has2_d = 1'b0;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_WALK_RD: begin
				cmd.rd_walk = 1'b1;
				state_d     = S_WALK_CHK;
			end
			S_WALK_CHK: begin
				cmd.rd_walk = 1'b1;
				if (stat.walk_end) begin
					op1_d   = sawarq_pkg::OP_DISC;
					has2_d  = 1'b0;
					state_d = S_EMIT;
				end else if (!stat.flagged) begin
					cmd.walk_adv = 1'b1;
					state_d      = S_WALK_RD;
				end else if (stat.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_op   = sawarq_pkg::OP_FAIL;
					cmd.walk_adv = 1'b1;
					state_d      = S_WALK_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			has2_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			has2_q  <= has2_d;
		end
	end

	always_ff @(posedge clk) begin
		op1_q <= op1_d;
		op2_q <= op2_d;
	end

`ifndef SYNTH
	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded over an untaken result");
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full)
		else $error("push into a full ring");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !stat.empty)
		else $error("pop from an empty ring");
	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_adv |-> !stat.walk_end)
		else $error("walk advanced past its end");
	a_fetch_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |=> state_q == S_EMIT)
		else $error("fetched head not emitted");
`endif

endmodule

>>> rtl/stop_and_wait_command_arq_top.sv
// Top level of the stop-and-wait command ARQ: controller and datapath.
// One request at a time: each passes a decide state, then emits its results, if any, from an emit state;
// a response that resends the next head first passes a fetch state for the ring read.
// A disconnect walks the pending ring entries (read and check states over one read port).
// Output stalls hold the emit and walk states; the next request is taken after the last result loads.
// Asynchronous active-low reset clears pointers, counters, link state; mask resets to 1.
module stop_and_wait_command_arq_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [31:0] seq,
	input  logic [15:0] cmd_handle,
	input  logic [15:0] cmd_length,
	input  logic [31:0] callback_type,
	input  logic [31:0] callback_data,
	input  logic [7:0]  reason,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [31:0] out_seq,
	output logic [15:0] out_handle,
	output logic [31:0] out_callback_type,
	output logic [31:0] out_callback_data,
	output logic [7:0]  out_reason,
	output logic        last
);

	sawarq_pkg::dp_cmd_t  cmd;
	sawarq_pkg::dp_stat_t stat;

	sawarq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sawarq_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.kind              (kind),
		.seq               (seq),
		.cmd_handle        (cmd_handle),
		.cmd_length        (cmd_length),
		.callback_type     (callback_type),
		.callback_data     (callback_data),
		.reason            (reason),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.action            (action),
		.out_seq           (out_seq),
		.out_handle        (out_handle),
		.out_callback_type (out_callback_type),
		.out_callback_data (out_callback_data),
		.out_reason        (out_reason),
		.last              (last),
		.cmd               (cmd),
		.stat              (stat)
	);

endmodule

>>> verif/tb_stop_and_wait_command_arq_top.sv
// Self-checking testbench for the stop-and-wait command ARQ top level.
module tb_stop_and_wait_command_arq_top;
	timeunit 1ns;
	timeprecision 1ps;

	// kinds outside the defined set, which the block drops
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 80;
	localparam int PHASE_ITEMS   = 23;
	localparam int CALM_ITEMS    = 15;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] seq;
		logic [15:0] handle;
		logic [15:0] length;
		logic [31:0] cb_type;
		logic [31:0] cb_data;
		logic [7:0]  reason;
	} arq_request_t;

	typedef struct packed {
		sawarq_pkg::action_t action;
		logic [31:0]         seq;
		logic [15:0]         handle;
		logic [31:0]         cb_type;
		logic [31:0]         cb_data;
		logic [7:0]          reason;
		logic                last;
	} arq_result_t;

	class arq_scoreboard;
		logic [31:0]      slot_seq[sawarq_pkg::QUEUE_DEPTH];
		logic [15:0]      slot_handle[sawarq_pkg::QUEUE_DEPTH];
		logic [31:0]      slot_cb_type[sawarq_pkg::QUEUE_DEPTH];
		logic [31:0]      slot_cb_data[sawarq_pkg::QUEUE_DEPTH];
		sawarq_pkg::ptr_t put_ptr;
		sawarq_pkg::ptr_t send_ptr;
		logic [31:0]      next_seq;
		logic [31:0]      expected_seq;
		bit               link_up;
		bit               sent_recently;
		logic [31:0]      flag_mask;
		arq_result_t      item_results[$];
		arq_result_t      expected_results[$];
		int unsigned      failures;

		function new();
			for (int i = 0; i < sawarq_pkg::QUEUE_DEPTH; i++) begin
				slot_seq[i] = '0;
				slot_handle[i] = '0;
				slot_cb_type[i] = '0;
				slot_cb_data[i] = '0;
			end
			put_ptr = '0;
			send_ptr = '0;
			next_seq = '0;
			expected_seq = '0;
			link_up = 1'b0;
			sent_recently = 1'b0;
			flag_mask = sawarq_pkg::MASK_RESET;
			failures = 0;
		endfunction

		function sawarq_pkg::ptr_t ring_step(sawarq_pkg::ptr_t p);
			return sawarq_pkg::ptr_t'((int'(p) + 1) % sawarq_pkg::QUEUE_DEPTH);
		endfunction

		function void add_result(sawarq_pkg::action_t a, logic [31:0] s, logic [15:0] h,
				logic [31:0] ct, logic [31:0] cd, logic [7:0] rs);
			arq_result_t r;
			r.action = a;
			r.seq = s;
			r.handle = h;
			r.cb_type = ct;
			r.cb_data = cd;
			r.reason = rs;
			r.last = 1'b0;
			item_results.push_back(r);
		endfunction

		// work out the results of one accepted request and queue them
		function void note_request(arq_request_t q);
			sawarq_pkg::ptr_t p;
			arq_result_t      tail;
			item_results.delete();
			case (q.kind)
				sawarq_pkg::KIND_QUEUE: begin
					if (!link_up || q.length > sawarq_pkg::MAX_CMD_LEN ||
							ring_step(put_ptr) == send_ptr) begin
						add_result(sawarq_pkg::ACT_REJECTED, '0, '0, '0, '0, '0);
					end else begin
						p = put_ptr;
						slot_seq[p] = next_seq;
						slot_handle[p] = q.handle;
						slot_cb_type[p] = q.cb_type;
						slot_cb_data[p] = q.cb_data;
						next_seq++;
						if (send_ptr == p) begin
							add_result(sawarq_pkg::ACT_SEND_CMD, slot_seq[p], q.handle,
								'0, '0, '0);
							sent_recently = 1'b1;
						end
						put_ptr = ring_step(p);
						add_result(sawarq_pkg::ACT_ACCEPTED, slot_seq[p], q.handle,
							'0, '0, '0);
					end
				end
				sawarq_pkg::KIND_TICK: begin
					if (link_up && put_ptr != send_ptr) begin
						if (sent_recently)
							sent_recently = 1'b0;
						else
							add_result(sawarq_pkg::ACT_SEND_CMD, slot_seq[send_ptr],
								slot_handle[send_ptr], '0, '0, '0);
					end
				end
				sawarq_pkg::KIND_RESP: begin
					if (put_ptr != send_ptr && slot_seq[send_ptr] == q.seq) begin
						slot_cb_type[send_ptr] = '0;
						slot_cb_data[send_ptr] = '0;
						send_ptr = ring_step(send_ptr);
						if (send_ptr != put_ptr) begin
							add_result(sawarq_pkg::ACT_SEND_CMD, slot_seq[send_ptr],
								slot_handle[send_ptr], '0, '0, '0);
							sent_recently = 1'b1;
						end
					end
				end
				sawarq_pkg::KIND_CMD: begin
					if (q.seq > expected_seq)
						expected_seq = q.seq;
					add_result(sawarq_pkg::ACT_SEND_RSP, q.seq, '0, '0, '0, '0);
					if (q.seq == expected_seq) begin
						add_result(sawarq_pkg::ACT_DELIVER, q.seq, q.handle, '0, '0, '0);
						expected_seq++;
					end
				end
				sawarq_pkg::KIND_CONN: begin
					if (q.reason == '0)
						link_up = 1'b1;
					add_result(sawarq_pkg::ACT_CONNECT, '0, '0, '0, '0, q.reason);
				end
				sawarq_pkg::KIND_DISC: begin
					link_up = 1'b0;
					// leave room for the disconnect report itself
					p = send_ptr;
					while (p != put_ptr &&
							item_results.size() < sawarq_pkg::MAX_RESULTS - 1) begin
						if ((slot_cb_type[p] & flag_mask) != '0)
							add_result(sawarq_pkg::ACT_FAILED, slot_seq[p], slot_handle[p],
								slot_cb_type[p], slot_cb_data[p], '0);
						p = ring_step(p);
					end
					add_result(sawarq_pkg::ACT_DISCONN, '0, '0, '0, '0, q.reason);
				end
				default: ;
			endcase
			if (item_results.size() > 0) begin
				tail = item_results.pop_back();
				tail.last = 1'b1;
				item_results.push_back(tail);
			end
			foreach (item_results[i])
				expected_results.push_back(item_results[i]);
		endfunction

		function void check_field(string name, logic [31:0] exp, logic [31:0] got);
			if (exp !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
				failures++;
			end
		endfunction

		function void check_result(arq_result_t got);
			arq_result_t exp;
			if (expected_results.size() == 0) begin
				$error("unexpected result: action %0d seq 0x%0h", got.action, got.seq);
				failures++;
				return;
			end
			exp = expected_results.pop_front();
			check_field("action", 32'(exp.action), 32'(got.action));
			check_field("out_seq", exp.seq, got.seq);
			check_field("out_handle", 32'(exp.handle), 32'(got.handle));
			check_field("out_callback_type", exp.cb_type, got.cb_type);
			check_field("out_callback_data", exp.cb_data, got.cb_data);
			check_field("out_reason", 32'(exp.reason), 32'(got.reason));
			check_field("last", 32'(exp.last), 32'(got.last));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  kind;
	logic [31:0] seq;
	logic [15:0] cmd_handle;
	logic [15:0] cmd_length;
	logic [31:0] callback_type;
	logic [31:0] callback_data;
	logic [7:0]  reason;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  action;
	logic [31:0] out_seq;
	logic [15:0] out_handle;
	logic [31:0] out_callback_type;
	logic [31:0] out_callback_data;
	logic [7:0]  out_reason;
	logic        last;

	arq_scoreboard sb;
	bit            calm = 1'b0;
	bit            hold_req = 1'b0;

	stop_and_wait_command_arq_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.kind              (kind),
		.seq               (seq),
		.cmd_handle        (cmd_handle),
		.cmd_length        (cmd_length),
		.callback_type     (callback_type),
		.callback_data     (callback_data),
		.reason            (reason),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.action            (action),
		.out_seq           (out_seq),
		.out_handle        (out_handle),
		.out_callback_type (out_callback_type),
		.out_callback_data (out_callback_data),
		.out_reason        (out_reason),
		.last              (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("stop_and_wait_command_arq_top regression: fail");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(posedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 38);
			end
		end
	end

	always @(posedge clk) begin
		arq_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.action = sawarq_pkg::action_t'(action);
			got.seq = out_seq;
			got.handle = out_handle;
			got.cb_type = out_callback_type;
			got.cb_data = out_callback_data;
			got.reason = out_reason;
			got.last = last;
			sb.check_result(got);
		end
	end

	function automatic arq_request_t make_req(logic [2:0] k, logic [31:0] s, logic [15:0] h,
			logic [15:0] len, logic [31:0] ct, logic [31:0] cd, logic [7:0] rs);
		arq_request_t q;
		q.kind = k;
		q.seq = s;
		q.handle = h;
		q.length = len;
		q.cb_type = ct;
		q.cb_data = cd;
		q.reason = rs;
		return q;
	endfunction

	// mostly well-formed traffic steered by the predicted link and ring state
	function automatic arq_request_t random_request();
		arq_request_t q;
		int unsigned  pick;
		int unsigned  sub;
		q.kind = sawarq_pkg::KIND_TICK;
		q.seq = $urandom;
		q.handle = 16'($urandom);
		q.length = 16'($urandom_range(sawarq_pkg::MAX_CMD_LEN));
		q.cb_type = $urandom;
		q.cb_data = $urandom;
		q.reason = '0;
		pick = $urandom_range(99);
		sub = $urandom_range(99);
		if (!sb.link_up && pick < 60) begin
			q.kind = sawarq_pkg::KIND_CONN;
			if (sub < 10)
				q.reason = 8'($urandom_range(255, 1));
		end else if (pick < 5) begin
			q.kind = 3'($urandom_range(7));
			q.length = 16'($urandom);
			q.reason = 8'($urandom);
		end else if (pick < 37) begin
			q.kind = sawarq_pkg::KIND_QUEUE;
			if (sub < 10)
				q.length = 16'($urandom_range(65535, 32'(sawarq_pkg::MAX_CMD_LEN) + 1));
			else if (sub < 35)
				q.cb_type = '0;
			else if (sub < 60)
				q.cb_type = 32'd1 << $urandom_range(31);
		end else if (pick < 60) begin
			q.kind = sawarq_pkg::KIND_RESP;
			if (sb.put_ptr != sb.send_ptr && sub < 80)
				q.seq = sb.slot_seq[sb.send_ptr];
			else if (sub < 90)
				q.seq = sb.slot_seq[sb.send_ptr] + 32'd1;
		end else if (pick < 72) begin
			q.kind = sawarq_pkg::KIND_TICK;
		end else if (pick < 85) begin
			q.kind = sawarq_pkg::KIND_CMD;
			if (sub < 50)
				q.seq = sb.expected_seq;
			else if (sub < 70)
				q.seq = sb.expected_seq - 32'($urandom_range(4, 1));
			else if (sub < 90)
				q.seq = sb.expected_seq + 32'($urandom_range(5, 1));
		end else if (pick < 93) begin
			q.kind = sawarq_pkg::KIND_CONN;
			if (sub < 20)
				q.reason = 8'($urandom);
		end else begin
			q.kind = sawarq_pkg::KIND_DISC;
			q.reason = 8'($urandom);
		end
		return q;
	endfunction

	task automatic offer_request(input arq_request_t q);
		if (!calm && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (!calm && $urandom_range(99) < 38);
		end
		in_valid <= 1'b1;
		kind <= q.kind;
		seq <= q.seq;
		cmd_handle <= q.handle;
		cmd_length <= q.length;
		callback_type <= q.cb_type;
		callback_data <= q.cb_data;
		reason <= q.reason;
		do @(posedge clk); while (in_stall);
		sb.note_request(q);
	endtask

	// drop valid, drain every expected result, then let a request with no result finish
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (sb.expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_flag_mask(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.flag_mask = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input logic [31:0] mask, input int count);
		arq_request_t q;
		int           n;
		drain_and_settle();
		write_flag_mask(mask);
		n = 0;
		while (n < count) begin
			q = random_request();
			offer_request(q);
			if (q.kind <= sawarq_pkg::KIND_DISC)
				n++;
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= sawarq_pkg::KIND_TICK;
		seq <= '0;
		cmd_handle <= '0;
		cmd_length <= '0;
		callback_type <= '0;
		callback_data <= '0;
		reason <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: link down, connect failure, length limit, ticks, responses,
		// received command ordering and wrap, dropped kinds, disconnect report
		offer_request(make_req(sawarq_pkg::KIND_QUEUE, '0, 16'h1234, 16'd10, 32'd1, 32'd2,
			'0));
		offer_request(make_req(sawarq_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0));
		offer_request(make_req(sawarq_pkg::KIND_RESP, '0, '0, '0, '0, '0, '0));
		offer_request(make_req(sawarq_pkg::KIND_CONN, '0, '0, '0, '0, '0, 8'h5A));
		offer_request(make_req(sawarq_pkg::KIND_QUEUE, '0, 16'h0001, 16'd1, 32'd1, '0, '0));
		offer_request(make_req(sawarq_pkg::KIND_CONN, '0, '0, '0, '0, '0, '0));
		offer_request(make_req(sawarq_pkg::KIND_QUEUE, '0, 16'hFFFF, 16'd1401, 32'd1, '0,
			'0));
		offer_request(make_req(sawarq_pkg::KIND_QUEUE, '0, 16'hFFFF, sawarq_pkg::MAX_CMD_LEN,
			32'd1, 32'hFFFF_FFFF, '0));
		offer_request(make_req(sawarq_pkg::KIND_QUEUE, '0, 16'h0000, 16'd0, 32'hFFFF_FFFF,
			32'hA5A5_5A5A, '0));
		offer_request(make_req(sawarq_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0));
		offer_request(make_req(sawarq_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0));
		offer_request(make_req(sawarq_pkg::KIND_RESP, 32'd5, '0, '0, '0, '0, '0));
		offer_request(make_req(sawarq_pkg::KIND_RESP, 32'd0, '0, '0, '0, '0, '0));
		offer_request(make_req(sawarq_pkg::KIND_CMD, 32'd0, 16'hBEEF, 16'hFFFF, '0, '0,
			8'hFF));
		offer_request(make_req(sawarq_pkg::KIND_CMD, 32'd0, 16'h0BAD, '0, '0, '0, '0));
		offer_request(make_req(sawarq_pkg::KIND_CMD, 32'd7, 16'h7777, '0, '0, '0, '0));
		offer_request(make_req(sawarq_pkg::KIND_CMD, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, '0,
			'0));
		offer_request(make_req(KIND_SPARE_LO, $urandom, 16'hFFFF, 16'hFFFF, $urandom,
			$urandom, 8'hFF));
		offer_request(make_req(KIND_SPARE_HI, '0, '0, '0, '0, '0, '0));
		offer_request(make_req(sawarq_pkg::KIND_DISC, '0, '0, '0, '0, '0, 8'hFF));

		// full ring with every entry flagged: fill, reject, widest disconnect
		drain_and_settle();
		write_flag_mask(32'hFFFF_FFFF);
		offer_request(make_req(sawarq_pkg::KIND_CONN, '0, '0, '0, '0, '0, '0));
		for (int i = 0; i < sawarq_pkg::QUEUE_DEPTH; i++)
			offer_request(make_req(sawarq_pkg::KIND_QUEUE, '0, 16'($urandom),
				16'($urandom_range(1400)), $urandom | 32'd1, $urandom, '0));
		offer_request(make_req(sawarq_pkg::KIND_DISC, '0, '0, '0, '0, '0, 8'h81));

		drain_and_settle();
		write_flag_mask('0);
		hold_req = 1'b1;
		random_phase('0, PHASE_ITEMS);
		calm = 1'b1;
		random_phase($urandom, CALM_ITEMS);
		calm = 1'b0;
		random_phase($urandom, PHASE_ITEMS - CALM_ITEMS);
		random_phase(32'hFFFF_FFFF, PHASE_ITEMS);
		random_phase(sawarq_pkg::MASK_RESET, PHASE_ITEMS);

		drain_and_settle();
		if (sb.expected_results.size() > 0) begin
			$error("%0d expected results never arrived", sb.expected_results.size());
			sb.failures++;
		end
		if (sb.failures == 0)
			$display("stop_and_wait_command_arq_top regression: pass");
		else
			$display("stop_and_wait_command_arq_top regression: fail");
		$finish;
	end

endmodule
